// File: sv/assert_macros.svh
// assertion helpers, clocked on i_clk; all but ASSERT_NEXT_ALWAYS are disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/spp_pkg.sv
`default_nettype none

package spp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [7:0] PUSH_MAX      = 8'd75;
    localparam logic [7:0] OP_PUSHDATA1  = 8'd76;
    localparam logic [7:0] OP_PUSHDATA2  = 8'd77;
    localparam logic [7:0] CS_PREFIX16   = 8'hFD;
    localparam logic [7:0] CS_PREFIX32   = 8'hFE;

    localparam logic [3:0] CS_BYTES16 = 4'd2;
    localparam logic [3:0] CS_BYTES32 = 4'd4;
    localparam logic [3:0] CS_BYTES64 = 4'd8;

    typedef enum logic [2:0] {
        PH_PREFIX      = 3'd0,
        PH_PREFIX_MORE = 3'd1,
        PH_LEADER      = 3'd2,
        PH_P1_LEN      = 3'd3,
        PH_P2_LO       = 3'd4,
        PH_P2_HI       = 3'd5,
        PH_DATA        = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_PREFIX = 2'd0,
        ROLE_LEADER = 2'd1,
        ROLE_LENGTH = 2'd2,
        ROLE_DATA   = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_OVERRUN = 2'd1,
        ERR_PREFIX  = 2'd2
    } t_err;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        t_role      role;
        logic [7:0] value;
        logic [7:0] leader;
        logic       first;
        logic       last;
        logic       script_end;
        t_err       err;
    } t_result;

endpackage

`default_nettype wire

// File: sv/script_push_parser_top.sv
// script push parser
// s_axis carries the raw script stream, one byte per transaction in tdata.
// m_axis returns one tagged result per input byte, in the same order.
// each script opens with a compact-size length prefix, then commands follow:
// leaders 1..75 push that many data bytes, 76 and 77 read a one- or two-byte
// little-endian length first, any other leader is a single opcode.
// once a command ends at or past the claimed length the next byte is a new
// prefix. bytes past the claimed length carry an overrun error.
// throughput: one byte per cycle, sustained while m_axis_tready is high; the
// parse state (phase, counters and the consumed-count increment and compare)
// updates once per byte. each byte is held in the input register, then its
// parse result is captured in the result register, which drives m_axis.
// if m_axis_tready is low the result holds, one more byte is taken into the
// input register, then s_axis_tready drops until the result is taken.
// reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to waiting for a length prefix.
`default_nettype none

module script_push_parser_top
    import spp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] stream_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [15:0]     m_axis_tdata,   // [7:0] byte_value, [15:8] command_leader
    output logic [7:0]      m_axis_tuser,   // [1:0] byte_role, [2] command_first,
                                            // [3] command_last, [5:4] error_code
    output logic            m_axis_tlast    // script_end
);

    t_in_item w_item;
    t_result  w_result;
    t_result  w_out;
    logic     w_advance;

    spp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_advance (w_advance),
        .o_ready   (s_axis_tready),
        .o_item    (w_item)
    );

    spp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (w_item.data),
        .o_result  (w_result)
    );

    spp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item.valid),
        .i_result     (w_result),
        .i_tready     (m_axis_tready),
        .o_advance    (w_advance),
        .o_tvalid     (m_axis_tvalid),
        .o_result     (w_out)
    );

    assign m_axis_tdata = {w_out.leader, w_out.value};
    assign m_axis_tuser = {2'b00, w_out.err, w_out.last, w_out.first, w_out.role};
    assign m_axis_tlast = w_out.script_end;

endmodule

`default_nettype wire

// File: sv/spp_in_stage.sv
`default_nettype none

module spp_in_stage
    import spp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data,
    input  wire logic       i_advance,
    output logic            o_ready,
    output t_in_item        o_item
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       w_accept;

    // slot is free when empty or when its byte moves on this cycle
    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_data;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.data  = r_data;

endmodule

`default_nettype wire

// File: sv/spp_parser.sv
`default_nettype none

module spp_parser
    import spp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    localparam logic [LENGTH_BITS-1:0] LEN_ONES = {LENGTH_BITS{1'b1}};

    t_phase                 r_phase,   n_phase;
    logic [3:0]             r_left,    n_left;
    logic [2:0]             r_pos,     n_pos;
    logic [LENGTH_BITS-1:0] r_claimed, n_claimed;
    logic [LENGTH_BITS-1:0] r_count,   n_count;
    logic [15:0]            r_push,    n_push;
    logic [7:0]             r_low,     n_low;
    logic [7:0]             r_leader,  n_leader;

    logic [63:0] w_shifted;
    logic        w_ovf;
    logic        w_prefix_done;
    logic        w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFIX;
            r_left    <= '0;
            r_pos     <= '0;
            r_claimed <= '0;
            r_count   <= '0;
            r_push    <= '0;
            r_low     <= '0;
            r_leader  <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_pos     <= n_pos;
            r_claimed <= n_claimed;
            r_count   <= n_count;
            r_push    <= n_push;
            r_low     <= n_low;
            r_leader  <= n_leader;
        end
    end

    // prefix byte placed at its little-endian position
    assign w_shifted = {56'd0, i_byte} << {r_pos, 3'b000};
    assign w_ovf     = |(w_shifted >> LENGTH_BITS);

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_pos     = r_pos;
        n_claimed = r_claimed;
        n_count   = r_count;
        n_push    = r_push;
        n_low     = r_low;
        n_leader  = r_leader;
        w_prefix_done = 1'b0;
        w_done        = 1'b0;

        o_result.role       = ROLE_PREFIX;
        o_result.value      = i_byte;
        o_result.leader     = '0;
        o_result.first      = 1'b0;
        o_result.last       = 1'b0;
        o_result.script_end = 1'b0;
        o_result.err        = ERR_NONE;

        unique case (r_phase)
            PH_PREFIX_MORE: begin
                if (w_ovf) begin
                    n_claimed    = LEN_ONES;
                    o_result.err = ERR_PREFIX;
                end else begin
                    n_claimed = r_claimed | w_shifted[LENGTH_BITS-1:0];
                end
                n_pos = r_pos + 3'd1;
                if (r_left != 4'd0) begin
                    n_left = r_left - 4'd1;
                end
                w_prefix_done = (n_left == 4'd0);
            end
            PH_LEADER, PH_P1_LEN, PH_P2_LO, PH_P2_HI, PH_DATA: begin
                if (r_count != LEN_ONES) begin
                    n_count = r_count + LENGTH_BITS'(1);
                end
                unique case (r_phase)
                    PH_LEADER: begin
                        o_result.role  = ROLE_LEADER;
                        o_result.first = 1'b1;
                        n_leader       = i_byte;
                        if (i_byte >= 8'd1 && i_byte <= PUSH_MAX) begin
                            n_push  = {8'd0, i_byte};
                            n_phase = PH_DATA;
                        end else if (i_byte == OP_PUSHDATA1) begin
                            n_phase = PH_P1_LEN;
                        end else if (i_byte == OP_PUSHDATA2) begin
                            n_phase = PH_P2_LO;
                        end else begin
                            w_done = 1'b1;
                        end
                    end
                    PH_P1_LEN: begin
                        o_result.role = ROLE_LENGTH;
                        n_push        = {8'd0, i_byte};
                        if (i_byte == 8'd0) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_P2_LO: begin
                        o_result.role = ROLE_LENGTH;
                        n_low         = i_byte;
                        n_phase       = PH_P2_HI;
                    end
                    PH_P2_HI: begin
                        o_result.role = ROLE_LENGTH;
                        n_push        = {i_byte, r_low};
                        if ({i_byte, r_low} == 16'd0) begin
                            w_done = 1'b1;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    default: begin
                        o_result.role = ROLE_DATA;
                        if (r_push != 16'd0) begin
                            n_push = r_push - 16'd1;
                        end
                        w_done = (n_push == 16'd0);
                    end
                endcase
                o_result.leader     = n_leader;
                o_result.script_end = (n_count >= r_claimed);
                if (n_count > r_claimed) begin
                    o_result.err = ERR_OVERRUN;
                end
                if (w_done) begin
                    o_result.last = 1'b1;
                    n_phase = o_result.script_end ? PH_PREFIX : PH_LEADER;
                end
            end
            default: begin
                // start of a script; the spare phase code lands here too
                n_claimed = '0;
                n_count   = '0;
                n_pos     = '0;
                if (i_byte < CS_PREFIX16) begin
                    n_claimed     = {{(LENGTH_BITS-8){1'b0}}, i_byte};
                    w_prefix_done = 1'b1;
                end else begin
                    n_left  = (i_byte == CS_PREFIX16) ? CS_BYTES16 :
                              (i_byte == CS_PREFIX32) ? CS_BYTES32 : CS_BYTES64;
                    n_phase = PH_PREFIX_MORE;
                end
            end
        endcase

        if (w_prefix_done) begin
            n_count = '0;
            n_pos   = '0;
            n_left  = '0;
            if (n_claimed == '0) begin
                o_result.script_end = 1'b1;
                n_phase = PH_PREFIX;
            end else begin
                n_phase = PH_LEADER;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/spp_out_stage.sv
`default_nettype none

module spp_out_stage
    import spp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_item_valid,
    input  t_result   i_result,
    input  wire logic i_tready,
    output logic      o_advance,
    output logic      o_tvalid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;

    // a byte is parsed when the result slot is empty or drains this cycle
    assign o_advance = i_item_valid && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: sv/spp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module spp_checker
    import spp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [7:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    logic        w_hold;
    logic [24:0] w_beat;
    logic        w_prefix_ok;

    assign w_hold      = m_axis_tvalid && !m_axis_tready;
    assign w_beat      = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
    assign w_prefix_ok = !m_axis_tuser[2] && !m_axis_tuser[3] &&
                         (m_axis_tuser[5:4] != ERR_OVERRUN);

    // a stalled result stays put
    `ASSERT_NEXT(a_stall_hold, w_hold, m_axis_tvalid && $stable(w_beat))

    // nothing comes out right after reset and the input side is open
    `ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !m_axis_tvalid && s_axis_tready)

    // only a leader byte opens a command
    `ASSERT_SAME(a_first_is_leader, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == ROLE_LEADER)

    // prefix bytes never mark command boundaries and carry no overrun
    `ASSERT_SAME(a_prefix_clean, m_axis_tvalid && m_axis_tuser[1:0] == ROLE_PREFIX, w_prefix_ok)

    // an overrun byte is always past the end of the script
    `ASSERT_SAME(a_overrun_end, m_axis_tvalid && m_axis_tuser[5:4] == ERR_OVERRUN, m_axis_tlast)

endmodule

bind script_push_parser_top spp_checker u_spp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
